// ===== rtl/w26_pkg.sv =====
// ----------------------------------------------------------------------------
// w26_pkg
// Shared constants, register map and helpers for the Wiegand 26 transmitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package w26_pkg;

    // Slot timer width; the timing registers are held at REG_WIDTH bits.
    localparam int TIMER_WIDTH = 16;
    localparam int REG_WIDTH   = 16;
    localparam int FRAME_BITS  = 26;
    localparam int BITS_WIDTH  = $clog2(FRAME_BITS + 1);

    // APB map: register i at byte address 4*i
    localparam int ADDR_WIDTH = 3;
    localparam int DATA_WIDTH = 32;
    localparam logic REG_PULSE  = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic [REG_WIDTH-1:0] PULSE_RESET  = REG_WIDTH'(200);
    localparam logic [REG_WIDTH-1:0] PERIOD_RESET = REG_WIDTH'(1000);

    // Input kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef logic [TIMER_WIDTH-1:0] timer_t;
    typedef logic [FRAME_BITS-1:0]  frame_t;

    localparam timer_t TIMER_MAX = {TIMER_WIDTH{1'b1}};

    // Zero acts as one tick; values above the timer range saturate.
    function automatic timer_t clamp_limit(input logic [REG_WIDTH-1:0] v);
        logic [32:0] x;
        logic [32:0] tmax;
        x    = (v == '0) ? 33'd1 : 33'(v);
        tmax = 33'(TIMER_MAX);
        clamp_limit = (x > tmax) ? TIMER_MAX : TIMER_WIDTH'(x);
    endfunction

    // Even parity over the first 12 payload bits, odd over the last 12.
    function automatic frame_t build_frame(input logic [7:0] b0,
                                           input logic [7:0] b1,
                                           input logic [7:0] b2);
        logic pe;
        logic po;
        pe = ^{b0, b1[7:4]};
        po = ~(^{b1[3:0], b2});
        build_frame = {pe, b0, b1, b2, po};
    endfunction

endpackage

// ===== rtl/wiegand26_frame_transmitter_top.sv =====
// ----------------------------------------------------------------------------
// wiegand26_frame_transmitter_top
// Wiegand 26-bit frame transmitter driven by one-microsecond tick beats.
// ----------------------------------------------------------------------------
// Each accepted input beat's result beat is registered and shows in the
// next cycle. One beat per cycle is taken while in_ready is high, that is
// while the result slot is free or being drained in the same cycle; the
// timer and shifter next state is computed from each accepted beat.
// Reset (rst_n, async, active low): idle, data and strobe lines high,
// pulse 200 ticks, period 1000 ticks, no result pending.
`timescale 1ns / 1ps

module wiegand26_frame_transmitter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [7:0]                      first_byte,
    input  logic [7:0]                      middle_byte,
    input  logic [7:0]                      last_byte,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            data_line,
    output logic                            strobe_line,
    output logic                            busy_res,
    output logic                            frame_done,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [w26_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [w26_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [w26_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready
);
    import w26_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEAD = 2'd1;
    localparam logic [1:0] PH_BITS = 2'd2;

    // ---- configuration registers ------------------------------------------
    logic [REG_WIDTH-1:0] pulse_reg;
    logic [REG_WIDTH-1:0] period_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Decode on the word address bit only; low byte bits are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg  <= PULSE_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_PULSE:  pulse_reg  <= pwdata[REG_WIDTH-1:0];
                REG_PERIOD: period_reg <= pwdata[REG_WIDTH-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_PULSE:  prdata = DATA_WIDTH'(pulse_reg);
            REG_PERIOD: prdata = DATA_WIDTH'(period_reg);
            default:    prdata = '0;
        endcase
    end

    // ---- transmitter state ------------------------------------------------
    // The state registers double as the result payload: they only move on
    // an accepted beat, which happens only while the result slot is free
    // or emptying, so a pending result never sees them change.
    logic [1:0]            phase_reg,   phase_next;
    frame_t                shift_reg,   shift_next;
    logic [BITS_WIDTH-1:0] left_reg,    left_next;
    timer_t                timer_reg,   timer_next;
    logic                  data_reg,    data_next;
    logic                  strobe_reg,  strobe_next;
    logic                  done_reg,    done_next;
    logic                  ovalid_reg;

    logic   in_fire;
    logic   busy;
    timer_t timer_inc;
    timer_t period;
    timer_t pulse;

    assign in_ready = !ovalid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign busy      = (phase_reg == PH_LEAD) || (phase_reg == PH_BITS);
    assign period    = clamp_limit(period_reg);
    assign pulse     = clamp_limit(pulse_reg);
    assign timer_inc = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        left_next   = left_reg;
        timer_next  = timer_reg;
        data_next   = data_reg;
        strobe_next = strobe_reg;
        done_next   = 1'b0;

        // a tick while idle falls through both arms and changes nothing
        if (kind == KIND_START)
        begin
            // start while busy is dropped
            if (!busy)
            begin
                shift_next  = build_frame(first_byte, middle_byte, last_byte);
                left_next   = BITS_WIDTH'(FRAME_BITS);
                timer_next  = '0;
                strobe_next = 1'b1;
                phase_next  = PH_LEAD;
            end
        end
        else if (busy)
        begin
            timer_next = timer_inc;
            if (timer_inc >= period)
            begin
                if (left_reg != '0)
                begin
                    // next slot: MSB out inverted, strobe low
                    data_next   = ~shift_reg[FRAME_BITS-1];
                    strobe_next = 1'b0;
                    shift_next  = {shift_reg[FRAME_BITS-2:0], 1'b0};
                    left_next   = left_reg - 1'b1;
                    timer_next  = '0;
                    phase_next  = PH_BITS;
                end
                else
                begin
                    // frame complete; data keeps the last bit level
                    strobe_next = 1'b1;
                    timer_next  = '0;
                    phase_next  = PH_IDLE;
                    done_next   = 1'b1;
                end
            end
            else if ((phase_reg == PH_BITS) && (timer_inc >= pulse))
            begin
                strobe_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            shift_reg  <= '0;
            left_reg   <= '0;
            timer_reg  <= '0;
            data_reg   <= 1'b1;
            strobe_reg <= 1'b1;
            done_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                shift_reg  <= shift_next;
                left_reg   <= left_next;
                timer_reg  <= timer_next;
                data_reg   <= data_next;
                strobe_reg <= strobe_next;
                done_reg   <= done_next;
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign data_line   = data_reg;
    assign strobe_line = strobe_reg;
    assign busy_res    = busy;
    assign frame_done  = done_reg;

endmodule

// ===== rtl/w26_checker.sv =====
// ----------------------------------------------------------------------------
// w26_checker
// Port-level checks for the Wiegand 26 transmitter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module w26_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            data_line,
    input logic                            strobe_line,
    input logic                            busy_res,
    input logic                            frame_done,
    input logic                            psel,
    input logic                            pready
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_line)
            && $stable(strobe_line) && $stable(busy_res) && $stable(frame_done))
        else $error("result beat changed while stalled");

    // input taken exactly when the result slot is free or draining
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow result slot");

    // completion leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> !busy_res)
        else $error("frame_done while still busy");

    // strobe is high whenever no frame is in flight
    a_idle_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> strobe_line)
        else $error("strobe low while idle");

    // config port never stalls
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low");

endmodule

bind wiegand26_frame_transmitter_top w26_checker u_w26_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Wiegand 26-bit frame transmitter: a directed
// table of beats, then randomised frames under several timing settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import w26_pkg::*;

    // Frame sequencer phases as the checker tracks them
    typedef enum logic [1:0] {PH_IDLE, PH_LEAD, PH_BITS} tx_phase_e;

    // One input beat
    typedef struct packed {
        logic       kind;
        logic [7:0] first_b;
        logic [7:0] middle_b;
        logic [7:0] last_b;
    } beat_t;

    // One result beat, field order as on the ports
    typedef struct packed {
        logic data;
        logic strobe;
        logic busy;
        logic done;
    } levels_t;

    // Directed table: either a beat or a register write
    typedef enum logic {ROW_BEAT, ROW_REG} row_op_e;

    typedef struct {
        row_op_e        op;
        logic           idx;
        logic [15:0]    val;
        beat_t          beat;
        bit             typed;
        levels_t        want;
    } row_t;

    // Random part: one timing setting per block of beats. Covers zero (acts as
    // one tick), pulse longer than period, pulse equal to period and both
    // registers at full scale.
    localparam int N_SETTINGS  = 8;
    localparam int PHASE_BEATS = 128;
    localparam logic [15:0] PULSE_PLAN  [N_SETTINGS] = '{1, 65535, 2, 0, 3, 1, 65535, 1};
    localparam logic [15:0] PERIOD_PLAN [N_SETTINGS] = '{1, 2, 3, 0, 3, 4, 65535, 2};

    // Longest honest quiet stretch is a long receiver stall on top of a long
    // sender gap plus some register traffic: well inside this limit.
    localparam int WATCHDOG_LIMIT = 1000;

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic                   kind        = KIND_TICK;
    logic [7:0]             first_byte  = '0;
    logic [7:0]             middle_byte = '0;
    logic [7:0]             last_byte   = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic                   data_line;
    logic                   strobe_line;
    logic                   busy_res;
    logic                   frame_done;
    logic                   psel        = 1'b0;
    logic                   penable     = 1'b0;
    logic                   pwrite      = 1'b0;
    logic [ADDR_WIDTH-1:0]  paddr       = '0;
    logic [DATA_WIDTH-1:0]  pwdata      = '0;
    logic [DATA_WIDTH-1:0]  prdata;
    logic                   pready;

    wiegand26_frame_transmitter_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .first_byte  (first_byte),
        .middle_byte (middle_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_line   (data_line),
        .strobe_line (strobe_line),
        .busy_res    (busy_res),
        .frame_done  (frame_done),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // Checker's copy of the transmitter: registers and frame state
    // ------------------------------------------------------------------------
    logic [REG_WIDTH-1:0]   cfg_pulse  = PULSE_RESET;
    logic [REG_WIDTH-1:0]   cfg_period = PERIOD_RESET;
    tx_phase_e              tx_phase   = PH_IDLE;
    frame_t                 tx_frame   = '0;
    logic [BITS_WIDTH-1:0]  tx_bits_left = '0;
    timer_t                 tx_timer   = '0;
    logic                   tx_data    = 1'b1;
    logic                   tx_strobe  = 1'b1;

    levels_t    levels_due[$];      // expected result beats, oldest first
    row_t       plan[$];            // directed table
    string      field_names[4] = '{"frame_done", "busy_res", "strobe_line", "data_line"};

    int         mismatches   = 0;
    int         beats_sent   = 0;
    int         results_seen = 0;
    int         frames_seen  = 0;
    int         stuck_cycles = 0;
    bit         no_idle      = 1'b0;

    // Register value as a timer limit: zero counts as one tick, anything past
    // the timer's range saturates.
    function automatic timer_t limit_of(input logic [REG_WIDTH-1:0] v);
        longint unsigned x;
        x = (v == '0) ? 64'd1 : 64'(v);
        return (x > 64'(TIMER_MAX)) ? TIMER_MAX : timer_t'(x);
    endfunction

    // Apply one accepted beat to the checker state and return the line levels
    // the block should report for it.
    function automatic levels_t next_levels(input beat_t b);
        levels_t r;
        timer_t  period;
        timer_t  pulse;
        r.done = 1'b0;
        if (b.kind == KIND_START) begin
            // start while a frame is on the wire is dropped
            if (tx_phase == PH_IDLE) begin
                tx_frame     = {^{b.first_b, b.middle_b[7:4]}, b.first_b, b.middle_b,
                                b.last_b, ~^{b.middle_b[3:0], b.last_b}};
                tx_bits_left = BITS_WIDTH'(FRAME_BITS);
                tx_timer     = '0;
                tx_strobe    = 1'b1;
                tx_phase     = PH_LEAD;
            end
        end else if (tx_phase != PH_IDLE) begin
            period = limit_of(cfg_period);
            pulse  = limit_of(cfg_pulse);
            if (tx_timer < TIMER_MAX)
                tx_timer++;
            if (tx_timer >= period) begin
                if (tx_bits_left != '0) begin
                    // new slot: data shows the inverted bit, strobe drops
                    tx_data      = ~tx_frame[FRAME_BITS-1];
                    tx_strobe    = 1'b0;
                    tx_frame     = tx_frame << 1;
                    tx_bits_left = tx_bits_left - 1'b1;
                    tx_timer     = '0;
                    tx_phase     = PH_BITS;
                end else begin
                    // frame over; data holds the last bit's level
                    tx_strobe = 1'b1;
                    tx_timer  = '0;
                    tx_phase  = PH_IDLE;
                    r.done    = 1'b1;
                end
            end else if (tx_phase == PH_BITS && tx_timer >= pulse) begin
                tx_strobe = 1'b1;
            end
        end
        r.data   = tx_data;
        r.strobe = tx_strobe;
        r.busy   = (tx_phase != PH_IDLE);
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("tb_top: mismatch: %s", msg);
    endtask

    // Mostly back to back, sometimes a short pause, now and then a long one
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic void add_beat(input logic k, input logic [7:0] b0,
                                     input logic [7:0] b1, input logic [7:0] b2,
                                     input bit typed, input levels_t want);
        row_t r;
        r.op    = ROW_BEAT;
        r.idx   = REG_PULSE;
        r.val   = '0;
        r.beat  = '{kind: k, first_b: b0, middle_b: b1, last_b: b2};
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endfunction

    function automatic void add_reg(input logic idx, input logic [15:0] val);
        row_t r;
        r.op    = ROW_REG;
        r.idx   = idx;
        r.val   = val;
        r.beat  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Bus tasks; each is entered and left at a falling edge unless noted
    // ------------------------------------------------------------------------

    // Present one beat and hold it until taken; the expectation is queued at
    // the accepting edge. Typed rows queue their own value instead.
    task automatic send_beat(input beat_t b, input bit typed, input levels_t want);
        levels_t predicted;
        in_valid    <= 1'b1;
        kind        <= b.kind;
        first_byte  <= b.first_b;
        middle_byte <= b.middle_b;
        last_byte   <= b.last_b;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = next_levels(b);
        levels_due.push_back(typed ? want : predicted);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic idle_gap();
        int n;
        n = no_idle ? 0 : pick_pause();
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Stop sending and let every outstanding result drain; ends after a rising
    // edge, which is fine since the register task re-aligns itself.
    task automatic settle();
        in_valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // One APB transfer. A write also updates the checker's copy; a read is
    // checked against it.
    task automatic reg_access(input logic wr, input logic idx, input logic [15:0] val);
        logic [DATA_WIDTH-1:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_WIDTH'({idx, 2'b00});
        pwdata  <= DATA_WIDTH'(val);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (wr) begin
            if (idx == REG_PULSE)
                cfg_pulse = val;
            else
                cfg_period = val;
        end else begin
            want = DATA_WIDTH'((idx == REG_PULSE) ? cfg_pulse : cfg_period);
            if (prdata !== want)
                note_mismatch($sformatf("register %0d read back %h, expected %h",
                                        idx, prdata, want));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure unless the current phase runs clean
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(0, 99) < 20) begin
                out_ready  <= 1'b0;
                stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                          : $urandom_range(7, 39);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare every result beat with the oldest expectation, field by field
    always @(posedge clk)
    begin
        levels_t got;
        levels_t want;
        if (rst_n && out_valid && out_ready) begin
            got = '{data: data_line, strobe: strobe_line, busy: busy_res, done: frame_done};
            if (levels_due.size() == 0) begin
                note_mismatch($sformatf("result %0d arrived with nothing expected",
                                        results_seen));
            end else begin
                want = levels_due.pop_front();
                for (int f = 3; f >= 0; f--)
                    if (got[f] !== want[f])
                        note_mismatch($sformatf("result %0d %s: expected %b, got %b",
                                                results_seen, field_names[f],
                                                want[f], got[f]));
            end
            if (got.done === 1'b1)
                frames_seen++;
            results_seen++;
        end
    end

    // Watchdog: any handshake on either channel or the register port counts
    // as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        beat_t b;
        int    useful;

        // Directed table. Typed rows are the ones obvious by inspection:
        // reset levels, start from idle, a start dropped while busy, end of
        // frame and the idle tick after it. Period 1 with pulse 0 means every
        // slot follows straight on with the strobe never going high between.
        add_beat(KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 4'b1100);
        add_reg(REG_PULSE, 16'd0);
        add_reg(REG_PERIOD, 16'd1);
        add_beat(KIND_START, 8'h00, 8'h00, 8'h00, 1'b1, 4'b1110);
        add_beat(KIND_START, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'b1110);
        for (int i = 0; i < FRAME_BITS; i++)
            add_beat(KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        // all-zero payload ends with odd parity 1, so data is left low
        add_beat(KIND_TICK, 8'h00, 8'h00, 8'h00, 1'b1, 4'b0101);
        add_beat(KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'b0100);
        add_beat(KIND_START, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'b0110);

        // Reset held low from the start, released on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers must read back their reset values
        reg_access(1'b0, REG_PULSE, '0);
        reg_access(1'b0, REG_PERIOD, '0);

        foreach (plan[i]) begin
            if (plan[i].op == ROW_REG) begin
                settle();
                reg_access(1'b1, plan[i].idx, plan[i].val);
            end else begin
                send_beat(plan[i].beat, plan[i].typed, plan[i].want);
                idle_gap();
            end
        end

        // Random part. Settings change only once the result side has drained,
        // though a frame may still be on the wire: the new timing then takes
        // over mid-frame. Every third setting runs without idling on either
        // side. Only beats that move the transmitter count toward the quota;
        // a few dropped starts go in as noise.
        for (int p = 0; p < N_SETTINGS; p++) begin
            settle();
            no_idle = (p % 3 == 0);
            reg_access(1'b1, REG_PULSE, PULSE_PLAN[p]);
            reg_access(1'b1, REG_PERIOD, PERIOD_PLAN[p]);
            reg_access(1'b0, REG_PULSE, '0);
            reg_access(1'b0, REG_PERIOD, '0);
            useful = 0;
            while (useful < PHASE_BEATS) begin
                b.first_b  = 8'($urandom_range(0, 255));
                b.middle_b = 8'($urandom_range(0, 255));
                b.last_b   = 8'($urandom_range(0, 255));
                if (tx_phase == PH_IDLE) begin
                    b.kind = ($urandom_range(0, 99) < 70) ? KIND_START : KIND_TICK;
                    if (b.kind == KIND_START)
                        useful++;
                end else begin
                    b.kind = ($urandom_range(0, 99) < 4) ? KIND_START : KIND_TICK;
                    if (b.kind == KIND_TICK)
                        useful++;
                end
                send_beat(b, 1'b0, '0);
                idle_gap();
            end
        end

        // Drain, then keep the clock running to catch any stray result beat
        no_idle = 1'b1;
        settle();
        repeat (8) @(posedge clk);

        $display("tb_top: %0d beats sent, %0d results checked, %0d frames completed",
                 beats_sent, results_seen, frames_seen);
        $display("tb_top: %0d timing settings incl. zero and full-scale registers, %0d mismatches",
                 N_SETTINGS + 1, mismatches);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
